>>> rtl/core/chd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chd_pkg: shared types and constants for the chunked body decoder
// Phase and result codes, parser state record and framing characters.
// ----------------------------------------------------------------------------
package chd_pkg;

    localparam int SIZE_BITS = 32;   // widest chunk size accepted
    localparam int TOTAL_W   = 32;   // running body total, saturating

    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;
    localparam logic [31:0]        LIMIT_RESET = 32'd1048576;

    localparam logic [7:0] CHR_CR = 8'h0D;
    localparam logic [7:0] CHR_LF = 8'h0A;

    typedef enum logic [7:0] {
        PH_SIZE    = 8'b0000_0001,
        PH_SIZE_LF = 8'b0000_0010,
        PH_DATA    = 8'b0000_0100,
        PH_TAIL1   = 8'b0000_1000,
        PH_TAIL2   = 8'b0001_0000,
        PH_LAST_CR = 8'b0010_0000,
        PH_LAST_LF = 8'b0100_0000,
        PH_STOPPED = 8'b1000_0000
    } t_phase;

    typedef enum logic [2:0] {
        K_CONSUMED  = 3'd0,
        K_BODY      = 3'd1,
        K_END_OK    = 3'd2,
        K_TOO_LARGE = 3'd3,
        K_FORMAT    = 3'd4
    } t_kind;

    typedef struct packed {
        t_phase                phase;
        logic [SIZE_BITS-1:0]  chunk_rem;
        logic [TOTAL_W-1:0]    body_total;
        logic                  digit_seen;
    } t_state;

    localparam t_state ST_RESET = '{
        phase:      PH_SIZE,
        chunk_rem:  '0,
        body_total: '0,
        digit_seen: 1'b0
    };

endpackage
`default_nettype wire

>>> rtl/core/chd_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chd_parse: per-byte parser step
// Computes the next parser state and the result for one input transaction.
// ----------------------------------------------------------------------------
module chd_parse (
    input  var chd_pkg::t_state i_state,
    input  wire                 i_cmd,
    input  wire  [7:0]          i_byte,
    input  wire  [31:0]         i_limit,
    output chd_pkg::t_state     o_state,
    output chd_pkg::t_kind      o_kind,
    output logic [7:0]          o_body_byte
);

    logic       hex_ok;
    logic [3:0] hex_val;
    logic [7:0] sub;

    // hex digit decode
    always_comb begin
        hex_ok  = 1'b1;
        sub     = 8'h00;
        case (i_byte) inside
            [8'h30:8'h39]: sub = i_byte - 8'h30;
            [8'h41:8'h46]: sub = i_byte - 8'h37;
            [8'h61:8'h66]: sub = i_byte - 8'h57;
            default:       hex_ok = 1'b0;
        endcase
        hex_val = sub[3:0];
    end

    always_comb begin
        o_state     = i_state;
        o_kind      = chd_pkg::K_CONSUMED;
        o_body_byte = 8'h00;
        if (i_cmd) begin
            o_state = chd_pkg::ST_RESET;
        end else begin
            case (i_state.phase)
                chd_pkg::PH_SIZE: begin
                    if (hex_ok) begin
                        // one more digit would overflow the size field
                        if (i_state.chunk_rem[chd_pkg::SIZE_BITS-1 -: 4] != 4'h0) begin
                            o_kind = chd_pkg::K_FORMAT;
                        end else begin
                            o_state.chunk_rem  = {i_state.chunk_rem[chd_pkg::SIZE_BITS-5:0],
                                                  hex_val};
                            o_state.digit_seen = 1'b1;
                        end
                    end else if (i_byte == chd_pkg::CHR_CR && i_state.digit_seen) begin
                        o_state.phase = chd_pkg::PH_SIZE_LF;
                    end else begin
                        o_kind = chd_pkg::K_FORMAT;
                    end
                end
                chd_pkg::PH_SIZE_LF: begin
                    if (i_byte != chd_pkg::CHR_LF) begin
                        o_kind = chd_pkg::K_FORMAT;
                    end else if (i_state.chunk_rem == '0) begin
                        o_state.phase = chd_pkg::PH_LAST_CR;
                    end else begin
                        o_state.phase = chd_pkg::PH_DATA;
                    end
                end
                chd_pkg::PH_DATA: begin
                    o_kind      = chd_pkg::K_BODY;
                    o_body_byte = i_byte;
                    if (i_state.body_total != chd_pkg::TOTAL_MAX) begin
                        o_state.body_total = i_state.body_total + 1'b1;
                    end
                    o_state.chunk_rem = i_state.chunk_rem - 1'b1;
                    if (i_state.chunk_rem == chd_pkg::SIZE_BITS'(1)) begin
                        o_state.phase = chd_pkg::PH_TAIL1;
                    end
                end
                chd_pkg::PH_TAIL1: begin
                    o_state.phase = chd_pkg::PH_TAIL2;
                end
                chd_pkg::PH_TAIL2: begin
                    if (i_state.body_total > i_limit) begin
                        o_kind = chd_pkg::K_TOO_LARGE;
                    end else begin
                        o_state.phase      = chd_pkg::PH_SIZE;
                        o_state.chunk_rem  = '0;
                        o_state.digit_seen = 1'b0;
                    end
                end
                chd_pkg::PH_LAST_CR: begin
                    if (i_byte == chd_pkg::CHR_CR) begin
                        o_state.phase = chd_pkg::PH_LAST_LF;
                    end else begin
                        o_kind = chd_pkg::K_FORMAT;
                    end
                end
                chd_pkg::PH_LAST_LF: begin
                    o_kind = (i_byte == chd_pkg::CHR_LF) ? chd_pkg::K_END_OK
                                                         : chd_pkg::K_FORMAT;
                end
                default: begin
                    // stopped: ignore bytes until restart
                end
            endcase
            if (o_kind == chd_pkg::K_END_OK || o_kind == chd_pkg::K_TOO_LARGE ||
                o_kind == chd_pkg::K_FORMAT) begin
                o_state.phase = chd_pkg::PH_STOPPED;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/http_chunked_body_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP chunked transfer body decoder
// Parses hex size lines, passes payload bytes, checks the body length limit.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                  payload
//  -------  ---------  -------------------------  ------------------------
//  in       input      i_in_valid / o_in_stall    i_cmd, i_raw_byte
//  out      output     o_out_valid / i_out_stall  o_kind, o_body_byte
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_data (body_limit)
//
//  One transaction per clock sustained while results are not stalled; every
//  input transaction yields exactly one result, via the input and result registers.
//  The loop that sets the rate is the parser state register, updated once
//  per byte as it moves from the input register into the result register.
//  Reset (synchronous, i_rst_n low) empties both registers, returns the
//  parser to the size-digit phase and loads body_limit with 1048576.
//  A stalled result holds; the input register then fills and o_in_stall rises.
//  cfg writes are always ready and take effect on the next parsed byte.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input byte stream
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_cmd,
    input  wire  [7:0]  i_raw_byte,
    // results
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_body_byte,
    // body_limit register write
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [31:0] i_cfg_data
);

    // input register
    logic            r_a_valid;
    logic            r_a_cmd;
    logic [7:0]      r_a_byte;
    // result register
    logic            r_b_valid;
    chd_pkg::t_kind  r_b_kind;
    logic [7:0]      r_b_byte;
    // parser state and limit
    chd_pkg::t_state r_st;
    chd_pkg::t_state n_st;
    logic [31:0]     r_limit;

    chd_pkg::t_kind  step_kind;
    logic [7:0]      step_byte;
    logic            in_take;
    logic            adv;

    // byte moves from input register into result register
    assign adv        = r_a_valid && (!r_b_valid || !i_out_stall);
    assign o_in_stall = r_a_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    chd_parse u_parse (
        .i_state     (r_st),
        .i_cmd       (r_a_cmd),
        .i_byte      (r_a_byte),
        .i_limit     (r_limit),
        .o_state     (n_st),
        .o_kind      (step_kind),
        .o_body_byte (step_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
        end else if (adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_cmd  <= i_cmd;
            r_a_byte <= i_raw_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_kind <= step_kind;
            r_b_byte <= step_byte;
        end
    end

    // parser state advances only with the byte it belongs to
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= chd_pkg::ST_RESET;
        end else if (adv) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= chd_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    assign o_out_valid = r_b_valid;
    assign o_kind      = r_b_kind;
    assign o_body_byte = r_b_byte;

`ifndef SYNTHESIS
    // payload byte is zero unless the result is a body byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_b_kind != chd_pkg::K_BODY) |-> (o_body_byte == 8'h00))
        else $error("body byte set on a non-body result");

    // a terminal result leaves the parser stopped until a restart
    a_end_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_b_kind == chd_pkg::K_END_OK ||
                         r_b_kind == chd_pkg::K_TOO_LARGE ||
                         r_b_kind == chd_pkg::K_FORMAT))
        |-> (r_st.phase == chd_pkg::PH_STOPPED))
        else $error("terminal result without stopped parser");

    // payload phase always has bytes left
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.phase == chd_pkg::PH_DATA) |-> (r_st.chunk_rem != '0))
        else $error("payload phase with empty chunk");

    // no digit seen means no size accumulated
    a_size_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.phase == chd_pkg::PH_SIZE && !r_st.digit_seen) |-> (r_st.chunk_rem == '0))
        else $error("size accumulated without a digit");

    // parser state only moves when a byte enters the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_st))
        else $error("parser state changed without a byte");
`endif

endmodule
`default_nettype wire

>>> tb/http_chunked_body_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_test: self-checking bench for the chunked decoder
// Streams directed and random chunked request bodies, with framing faults,
// into the decoder under random idle and stall. A shadow parser predicts each
// result, and every result is checked in order against its prediction. The
// body limit is rewritten between phases while the decoder is quiet.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_test;

    localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES = 10;      // two-register pipe, plus margin
    localparam int IDLE_PCT     = 23;
    localparam int PHASE_ITEMS  = 95;      // minimum counted bytes per phase, six phases

    typedef struct packed {
        logic       cmd;
        logic [7:0] raw;
    } t_stream_item;

    typedef struct packed {
        chd_pkg::t_kind kind;
        logic [7:0]     body;
    } t_decode;

    // DUT ports, inputs all known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_cmd       = 1'b0;
    logic [7:0]  i_raw_byte  = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [31:0] i_cfg_data  = 32'h0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_kind;
    logic [7:0]  o_body_byte;
    logic        o_cfg_ready;

    http_chunked_body_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_raw_byte  (i_raw_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_body_byte (o_body_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    t_stream_item byte_queue[$];        // bytes waiting for the driver
    t_decode      expected_results[$];  // predictions not yet matched
    logic [7:0]   req_bytes[$];         // scratch for building one request

    t_stream_item next_item;
    t_decode      want;

    int unsigned  queued_count   = 0;   // items handed to the driver
    int unsigned  accepted_count = 0;   // input transactions taken
    int unsigned  checked_count  = 0;   // result transactions matched
    int unsigned  fault_count    = 0;
    int unsigned  cycle_count    = 0;
    int unsigned  cfg_asked      = 0;
    int unsigned  cfg_done       = 0;
    logic [31:0]  cfg_value      = 32'h0;
    bit           calm           = 1'b0; // no idling on either side

    // Shadow parser state, owned by the driver block; limit_shadow by the write port
    chd_pkg::t_phase              parse_phase;
    logic [chd_pkg::SIZE_BITS-1:0] size_acc;  // size being parsed, then bytes left
    logic [31:0]                  body_sum;   // saturating body total
    bit                           digits_seen;
    logic [31:0]                  limit_shadow = chd_pkg::LIMIT_RESET;

    // ------------------------------------------------------------------
    // Shadow parser
    // ------------------------------------------------------------------
    function automatic void clear_parser();
        parse_phase = chd_pkg::PH_SIZE;
        size_acc    = '0;
        body_sum    = '0;
        digits_seen = 1'b0;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    // One byte through the parser; returns the result it must produce.
    function automatic t_decode decode_byte(input logic cmd, input logic [7:0] b);
        t_decode r;
        int      nib;
        r.kind = chd_pkg::K_CONSUMED;
        r.body = 8'h00;
        if (cmd) begin
            clear_parser();             // limit survives a restart
        end else begin
            case (parse_phase)
                chd_pkg::PH_SIZE: begin
                    nib = hex_nibble(b);
                    if (nib >= 0) begin
                        // one more digit would overflow the size field
                        if (size_acc[chd_pkg::SIZE_BITS-1 -: 4] != 4'h0) begin
                            r.kind = chd_pkg::K_FORMAT;
                        end else begin
                            size_acc    = {size_acc[chd_pkg::SIZE_BITS-5:0], nib[3:0]};
                            digits_seen = 1'b1;
                        end
                    end else if (b == chd_pkg::CHR_CR && digits_seen) begin
                        parse_phase = chd_pkg::PH_SIZE_LF;
                    end else begin
                        r.kind = chd_pkg::K_FORMAT;  // junk, extension, or empty line
                    end
                end
                chd_pkg::PH_SIZE_LF: begin
                    if (b != chd_pkg::CHR_LF)
                        r.kind = chd_pkg::K_FORMAT;
                    else
                        parse_phase = (size_acc == '0) ? chd_pkg::PH_LAST_CR
                                                       : chd_pkg::PH_DATA;
                end
                chd_pkg::PH_DATA: begin
                    r.kind = chd_pkg::K_BODY;
                    r.body = b;
                    if (body_sum != chd_pkg::TOTAL_MAX)
                        body_sum = body_sum + 32'd1;
                    size_acc = size_acc - chd_pkg::SIZE_BITS'(1);
                    if (size_acc == '0)
                        parse_phase = chd_pkg::PH_TAIL1;
                end
                chd_pkg::PH_TAIL1: begin
                    parse_phase = chd_pkg::PH_TAIL2;   // tail bytes are not checked
                end
                chd_pkg::PH_TAIL2: begin
                    if (body_sum > limit_shadow) begin
                        r.kind = chd_pkg::K_TOO_LARGE;
                    end else begin
                        parse_phase = chd_pkg::PH_SIZE;
                        size_acc    = '0;
                        digits_seen = 1'b0;
                    end
                end
                chd_pkg::PH_LAST_CR: begin
                    if (b == chd_pkg::CHR_CR)
                        parse_phase = chd_pkg::PH_LAST_LF;
                    else
                        r.kind = chd_pkg::K_FORMAT;    // trailers are refused
                end
                chd_pkg::PH_LAST_LF: begin
                    r.kind = (b == chd_pkg::CHR_LF) ? chd_pkg::K_END_OK
                                                    : chd_pkg::K_FORMAT;
                end
                default: ;                      // stopped: ignore until restart
            endcase
            if (r.kind == chd_pkg::K_END_OK || r.kind == chd_pkg::K_TOO_LARGE ||
                r.kind == chd_pkg::K_FORMAT)
                parse_phase = chd_pkg::PH_STOPPED;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: presents queued bytes, predicts on each transaction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            clear_parser();
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(decode_byte(i_cmd, i_raw_byte));
                accepted_count <= accepted_count + 1;
            end
            // load a new byte only when the current one is gone
            if (!i_in_valid || !o_in_stall) begin
                if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    next_item = byte_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_cmd      <= next_item.cmd;
                    i_raw_byte <= next_item.raw;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random stall, in-order compare against predictions
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    if (fault_count < 10)
                        $display("unexpected result: kind %0d body %02h", o_kind, o_body_byte);
                    fault_count <= fault_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    checked_count <= checked_count + 1;
                    if (o_kind !== want.kind || o_body_byte !== want.body) begin
                        if (fault_count < 10)
                            $display({"mismatch at result %0d: kind exp %0d got %0d, ",
                                      "body exp %02h got %02h"},
                                     checked_count, want.kind, o_kind, want.body,
                                     o_body_byte);
                        fault_count <= fault_count + 1;
                    end
                end
            end
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // body_limit write port: one transaction per request from the sequencer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid  <= 1'b0;
            limit_shadow <= chd_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            i_cfg_valid  <= 1'b0;
            limit_shadow <= i_cfg_data;
            cfg_done     <= cfg_done + 1;
        end else if (!i_cfg_valid && cfg_done != cfg_asked) begin
            i_cfg_valid <= 1'b1;
            i_cfg_data  <= cfg_value;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic cmd, input logic [7:0] raw);
        t_stream_item it;
        it.cmd = cmd;
        it.raw = raw;
        byte_queue.push_back(it);
        queued_count++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return 8'h30 + v;
        return (upper ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    // Size line: optional leading zeros, mixed-case hex, then CR LF
    task automatic put_size(input logic [31:0] value);
        int n;
        int i;
        n = 1;
        while (n < 8 && (value >> (4 * n)) != 0)
            n++;
        repeat ($urandom_range(2)) req_bytes.push_back("0");
        for (i = n - 1; i >= 0; i--)
            req_bytes.push_back(hex_char(value[4*i +: 4], 1'($urandom_range(1))));
        req_bytes.push_back(chd_pkg::CHR_CR);
        req_bytes.push_back(chd_pkg::CHR_LF);
    endtask

    // One request: restart, up to three chunks, last chunk; some get a framing fault.
    task automatic gen_request(output int useful);
        int chunks;
        int len;
        int mode;
        int cut;
        int i;
        int j;
        req_bytes.delete();
        chunks = $urandom_range(3);
        for (i = 0; i < chunks; i++) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(6, 1);
            put_size(len);
            for (j = 0; j < len; j++)
                req_bytes.push_back(8'($urandom_range(255)));
            if ($urandom_range(6) == 0) begin
                // tail content is not checked by the decoder
                req_bytes.push_back(8'($urandom_range(255)));
                req_bytes.push_back(8'($urandom_range(255)));
            end else begin
                req_bytes.push_back(chd_pkg::CHR_CR);
                req_bytes.push_back(chd_pkg::CHR_LF);
            end
        end
        put_size(0);
        mode = $urandom_range(99);
        if (mode < 6) begin
            // trailer header after the last chunk: refused
            req_bytes.push_back("X");
            req_bytes.push_back(":");
            req_bytes.push_back("1");
            req_bytes.push_back(chd_pkg::CHR_CR);
            req_bytes.push_back(chd_pkg::CHR_LF);
        end
        req_bytes.push_back(chd_pkg::CHR_CR);
        req_bytes.push_back(chd_pkg::CHR_LF);

        if (mode >= 6 && mode < 16) begin
            // one corrupted byte anywhere
            req_bytes[$urandom_range(req_bytes.size() - 1)] = 8'($urandom_range(255));
        end else if (mode >= 16 && mode < 22) begin
            // cut short, next restart lands mid-frame
            cut = $urandom_range(req_bytes.size() - 1);
            while (req_bytes.size() > cut)
                void'(req_bytes.pop_back());
        end else if (mode >= 22 && mode < 28) begin
            // size line with more digits than the size field holds
            req_bytes.delete();
            req_bytes.push_back(hex_char(4'($urandom_range(15, 1)), 1'($urandom_range(1))));
            repeat ($urandom_range(9, 8))
                req_bytes.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
        end else if (mode >= 28 && mode < 32) begin
            req_bytes.delete();
            repeat ($urandom_range(8, 3))
                req_bytes.push_back(8'($urandom_range(255)));
        end

        push_item(1'b1, 8'($urandom_range(255)));
        foreach (req_bytes[k])
            push_item(1'b0, req_bytes[k]);
        useful = req_bytes.size() + 1;

        // stray bytes after the request ends; not counted, ignored once the parser stopped
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(3, 1)) push_item(1'b0, 8'($urandom_range(255)));
    endtask

    // Sender holds off until every queued byte has its result checked.
    // Counters only lag, so a stale read can only delay the exit.
    task automatic wait_idle();
        while (accepted_count != queued_count || checked_count != accepted_count)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        cfg_value <= value;
        cfg_asked <= cfg_asked + 1;
        @(posedge i_clk);
        while (cfg_done != cfg_asked)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        int made;
        int n;
        int p;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (p = 0; p < 6; p++) begin
            // phase 0 runs on the reset limit; the rest cover both extremes
            case (p)
                1:       write_limit(32'h0);
                2:       write_limit(32'hFFFF_FFFF);
                3:       write_limit(32'd12);
                4:       write_limit($urandom_range(60));
                5:       write_limit(32'd25);
                default: ;
            endcase
            calm = (p == 2);

            if (p == 0) begin
                // clean body with extreme payload bytes, then a stray byte
                push_item(1'b0, "2");
                push_item(1'b0, chd_pkg::CHR_CR);
                push_item(1'b0, chd_pkg::CHR_LF);
                push_item(1'b0, 8'h00);
                push_item(1'b0, 8'hFF);
                push_item(1'b0, chd_pkg::CHR_CR);
                push_item(1'b0, chd_pkg::CHR_LF);
                push_item(1'b0, "0");
                push_item(1'b0, chd_pkg::CHR_CR);
                push_item(1'b0, chd_pkg::CHR_LF);
                push_item(1'b0, chd_pkg::CHR_CR);
                push_item(1'b0, chd_pkg::CHR_LF);
                push_item(1'b0, "z");
                // empty size line
                push_item(1'b1, 8'h00);
                push_item(1'b0, chd_pkg::CHR_CR);
                // nine digits: the last one overflows the size
                push_item(1'b1, 8'hFF);
                repeat (9) push_item(1'b0, "F");
            end

            made = 0;
            while (made < PHASE_ITEMS) begin
                gen_request(n);
                made += n;
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0d results never arrived", expected_results.size());
            fault_count = fault_count + 1;
        end
        if (fault_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
